FILE: rtl/i2a_pkg.sv
// Package for the integer to ASCII formatter.
// Shared widths, constants and digit encoding; no dependencies.
`default_nettype none
package i2a_pkg;
  localparam int ValueBits = 32;
  localparam int NumDigits = 10;
  localparam int CntBits   = 4;
  localparam int BcdBits   = NumDigits * 4;
  localparam logic RadixDec = 1'b0;
  localparam logic RadixHex = 1'b1;

  typedef struct packed {
    logic             hex;
    logic [BcdBits-1:0] digits;
  } conv_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    begin
      if (d < 4'd10) c = 7'h30 + {3'd0, d};
      else c = 7'h37 + {3'd0, d};
      digit_char = c;
    end
  endfunction
endpackage
`default_nettype wire

FILE: rtl/i2a_convert.sv
// Pipelined binary to BCD conversion (double dabble), four bits per stage.
// Depends on i2a_pkg.
`default_nettype none
module i2a_convert (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic                         in_hex,
  input  wire logic [i2a_pkg::ValueBits-1:0] in_value,
  output logic                              out_valid,
  output i2a_pkg::conv_t                    out_conv
);
  localparam int Stages = i2a_pkg::ValueBits / 4;

  logic                                 vld [Stages+1];
  logic                                 hx  [Stages+1];
  logic [i2a_pkg::ValueBits-1:0]         bin [Stages+1];
  logic [i2a_pkg::BcdBits-1:0]           bcd [Stages+1];

  always_comb begin
    vld[0] = in_valid;
    hx[0]  = in_hex;
    bin[0] = in_value;
    bcd[0] = '0;
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [i2a_pkg::BcdBits-1:0] b;
    always_comb begin
      b = bcd[s];
      for (int k = 0; k < 4; k++) begin
        for (int d = 0; d < i2a_pkg::NumDigits; d++) begin
          if (b[d*4 +: 4] >= 4'd5) b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
        b = {b[i2a_pkg::BcdBits-2:0], bin[s][i2a_pkg::ValueBits-1-k]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        hx[s+1]  <= hx[s];
        bin[s+1] <= {bin[s][i2a_pkg::ValueBits-5:0], 4'd0};
        bcd[s+1] <= b;
      end
    end
  end

  // hex bypass: keep raw nibbles, padded
  logic [i2a_pkg::ValueBits-1:0] raw [Stages+1];
  always_comb raw[0] = in_value;
  for (genvar s = 0; s < Stages; s++) begin : g_raw
    always_ff @(posedge clk) begin
      if (en) raw[s+1] <= raw[s];
    end
  end

  assign out_valid = vld[Stages];
  always_comb begin
    out_conv.hex = hx[Stages];
    if (hx[Stages] == i2a_pkg::RadixHex)
      out_conv.digits = {{(i2a_pkg::BcdBits-i2a_pkg::ValueBits){1'b0}}, raw[Stages]};
    else
      out_conv.digits = bcd[Stages];
  end
endmodule
`default_nettype wire

FILE: rtl/integer_to_ascii_formatter.sv
// Integer to ASCII formatter: 8-stage BCD pipeline, then a serializer
// emitting one character per cycle while out_stall is low.
// The serializer paces input: a new item enters as the prior last char is accepted.
// Synchronous active-high reset clears all valid bits.
// Depends on i2a_pkg and i2a_convert.
`default_nettype none
module integer_to_ascii_formatter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       ascii_char,
  output logic             last
);
  logic           cv;
  i2a_pkg::conv_t cc;
  logic           en;
  logic           busy;
  logic [i2a_pkg::BcdBits-1:0] dig;
  logic [i2a_pkg::CntBits-1:0] idx;
  logic [i2a_pkg::CntBits-1:0] top;
  logic           take;

  assign take = cv && (!busy || (out_valid && !out_stall && last));
  assign en   = !cv || take;
  assign in_stall = !en;

  i2a_convert u_conv (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .in_hex(req_type),
    .in_value(value), .out_valid(cv), .out_conv(cc)
  );

  always_comb begin
    top = '0;
    for (int d = 1; d < i2a_pkg::NumDigits; d++) begin
      if (cc.digits[d*4 +: 4] != 4'd0) top = i2a_pkg::CntBits'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (take) begin
      busy <= 1'b1;
    end else if (out_valid && !out_stall && last) begin
      busy <= 1'b0;
    end
    if (take) begin
      dig <= cc.digits;
      idx <= top;
    end else if (out_valid && !out_stall && !last) begin
      idx <= idx - 1'b1;
    end
  end

  assign out_valid  = busy;
  assign ascii_char = i2a_pkg::digit_char(dig[idx*4 +: 4]);
  assign last       = (idx == '0);
endmodule
`default_nettype wire
